// ===== hw/rtl/gap_run_length_histogram_defines.svh =====
// Assertion macros for the gap run-length histogram RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GAP_RUN_LENGTH_HISTOGRAM_DEFINES_SVH
`define GAP_RUN_LENGTH_HISTOGRAM_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define GRLH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GRLH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/grlh_pkg.sv =====
// Shared constants for the gap run-length histogram: field widths, command codes,
// register reset value. No dependencies.
`default_nettype none

package grlh_pkg;

    localparam int CMD_WIDTH    = 2;
    localparam int SYMBOL_WIDTH = 8;
    localparam int INDEX_WIDTH  = 12;
    localparam int OUT_WIDTH    = 32;

    localparam logic [CMD_WIDTH-1:0] CMD_PUSH        = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_READ_BIN    = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_READ_TOTALS = 2'd2;

    localparam logic [SYMBOL_WIDTH-1:0] GAP_SYMBOL_RESET = 8'd45;

endpackage

`default_nettype wire

// ===== hw/rtl/grlh_ifs.sv =====
// Valid/ready channel interfaces for the histogram's command and result streams.
// Depends on grlh_pkg for field widths.
`default_nettype none

interface grlh_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [grlh_pkg::CMD_WIDTH-1:0]       cmd;
    logic [grlh_pkg::SYMBOL_WIDTH-1:0]    symbol;
    logic                                 end_of_sequence;
    logic [grlh_pkg::INDEX_WIDTH-1:0]     bin_index;

    modport source (output valid, cmd, symbol, end_of_sequence, bin_index, input ready);
    modport sink   (input valid, cmd, symbol, end_of_sequence, bin_index, output ready);
endinterface

interface grlh_out_if;
    logic                               valid;
    logic                               ready;
    logic [grlh_pkg::OUT_WIDTH-1:0]     bin_count;
    logic [grlh_pkg::OUT_WIDTH-1:0]     gap_runs;
    logic [grlh_pkg::OUT_WIDTH-1:0]     frameshift_runs;
    logic [grlh_pkg::OUT_WIDTH-1:0]     phase_zero_runs;
    logic [grlh_pkg::OUT_WIDTH-1:0]     phase_one_runs;
    logic [grlh_pkg::OUT_WIDTH-1:0]     phase_two_runs;

    modport source (output valid, bin_count, gap_runs, frameshift_runs, phase_zero_runs,
                    phase_one_runs, phase_two_runs, input ready);
    modport sink   (input valid, bin_count, gap_runs, frameshift_runs, phase_zero_runs,
                    phase_one_runs, phase_two_runs, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gap_run_length_histogram.sv =====
// Gap run-length histogram top level: run tracking, histogram RAM with
// read-modify-write and forwarding, totals, output register. Uses grlh_pkg, grlh_ifs.
//
//   channel   dir   handshake        payload
//   i_in      in    valid/ready      cmd, symbol, end_of_sequence, bin_index
//   o_out     out   valid/ready      bin_count, gap_runs, frameshift_runs, phase_*_runs
//   i_cfg_*   in    write enable     gap symbol, 8 bits
//
// One item per cycle sustained while o_out.ready is high and no clear is running.
// The histogram RAM read is registered into the RMW stage, which increments and, for a close, writes back;
// back-to-back closes on one bin are forwarded from the write-back stage.
// After reset the RAM is cleared one bin per cycle, with i_in.ready low until all bins are clear.
// With o_out.ready low, up to two items are held (RMW stage and output register).
`default_nettype none

`include "gap_run_length_histogram_defines.svh"

module gap_run_length_histogram #(
    parameter int HIST_DEPTH  = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [grlh_pkg::SYMBOL_WIDTH-1:0]   i_cfg_wr_data,
    grlh_in_if.sink                                  i_in,
    grlh_out_if.source                               o_out
);

    localparam int AW = $clog2(HIST_DEPTH);
    localparam int IW = grlh_pkg::INDEX_WIDTH;
    localparam int OW = grlh_pkg::OUT_WIDTH;
    localparam logic [AW-1:0]          LAST_BIN = AW'(HIST_DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] runs;
        logic [COUNT_WIDTH-1:0] frame;
        logic [COUNT_WIDTH-1:0] ph0;
        logic [COUNT_WIDTH-1:0] ph1;
        logic [COUNT_WIDTH-1:0] ph2;
    } t_totals;

    // histogram storage
    logic [COUNT_WIDTH-1:0] mem [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0] r_mem_q;

    // run tracking and configuration
    logic [grlh_pkg::SYMBOL_WIDTH-1:0] r_gap_symbol;
    logic [AW-1:0] r_run_len, n_run_len;
    logic [1:0]    r_run_res, n_run_res;
    logic [1:0]    r_col, n_col;
    logic [1:0]    r_start_ph, n_start_ph;
    t_totals       r_tot, n_tot;

    // clearing pass
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    // RMW stage
    logic          r_b_valid;
    logic          r_b_close;
    logic          r_b_read;
    logic [AW-1:0] r_b_addr;
    t_totals       r_b_tot;
    logic          r_fwd_hit;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    // output register
    logic          r_c_valid;
    logic [OW-1:0] r_c_bin;
    t_totals       r_c_tot;

    // front-end decode
    logic          accept;
    logic          is_push, is_gap, eos, fresh, close;
    logic [AW-1:0] g_len, close_len, rd_addr, idx_addr;
    logic [1:0]    g_res, g_res_base, close_res, g_ph, close_ph;
    logic          idx_in_range;
    logic [AW+IW-1:0] idx_ext;

    logic                   b_adv, b_wr_en;
    logic [COUNT_WIDTH-1:0] b_data, b_inc;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    assign b_adv   = r_b_valid && (!r_c_valid || o_out.ready);
    assign b_wr_en = b_adv && r_b_close;
    assign b_data  = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign b_inc   = sat_inc(b_data);

    assign i_in.ready = !r_clr_active && (!r_b_valid || b_adv);
    assign accept     = i_in.valid && i_in.ready;

    assign idx_ext      = (AW + IW)'(i_in.bin_index);
    assign idx_addr     = idx_ext[AW-1:0];
    assign idx_in_range = 32'(i_in.bin_index) < 32'(HIST_DEPTH);

    always_comb begin
        is_push    = i_in.cmd == grlh_pkg::CMD_PUSH;
        is_gap     = i_in.symbol == r_gap_symbol;
        eos        = i_in.end_of_sequence;
        fresh      = r_run_len == '0;

        g_len      = fresh ? AW'(1) : ((r_run_len != LAST_BIN) ? r_run_len + AW'(1) : r_run_len);
        g_res_base = fresh ? 2'd0 : r_run_res;
        g_res      = (g_res_base == 2'd2) ? 2'd0 : g_res_base + 2'd1;
        g_ph       = fresh ? r_col : r_start_ph;

        close      = is_push && (is_gap ? eos : !fresh);
        close_len  = is_gap ? g_len : r_run_len;
        close_res  = is_gap ? g_res : r_run_res;
        close_ph   = is_gap ? g_ph : r_start_ph;

        rd_addr    = close ? close_len : idx_addr;

        n_run_len  = r_run_len;
        n_run_res  = r_run_res;
        n_start_ph = r_start_ph;
        n_col      = r_col;
        n_tot      = r_tot;
        if (is_push) begin
            if (is_gap && !eos) begin
                n_run_len  = g_len;
                n_run_res  = g_res;
                n_start_ph = g_ph;
            end else begin
                n_run_len  = '0;
                n_run_res  = 2'd0;
            end
            n_col = (eos || r_col == 2'd2) ? 2'd0 : r_col + 2'd1;
        end
        if (close) begin
            n_tot.runs = sat_inc(r_tot.runs);
            if (close_res != 2'd0) begin
                n_tot.frame = sat_inc(r_tot.frame);
            end
            case (close_ph)
                2'd0:    n_tot.ph0 = sat_inc(r_tot.ph0);
                2'd1:    n_tot.ph1 = sat_inc(r_tot.ph1);
                default: n_tot.ph2 = sat_inc(r_tot.ph2);
            endcase
        end
    end

    // histogram RAM: one write port (clear or write-back), one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem[r_clr_addr] <= '0;
        end else if (b_wr_en) begin
            mem[r_b_addr] <= b_inc;
        end
        if (accept) begin
            r_mem_q    <= mem[rd_addr];
            r_fwd_data <= b_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_symbol <= grlh_pkg::GAP_SYMBOL_RESET;
            r_run_len    <= '0;
            r_run_res    <= 2'd0;
            r_col        <= 2'd0;
            r_start_ph   <= 2'd0;
            r_tot        <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_b_valid    <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_c_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap_symbol <= i_cfg_wr_data;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_BIN) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (accept) begin
                r_run_len  <= n_run_len;
                r_run_res  <= n_run_res;
                r_col      <= n_col;
                r_start_ph <= n_start_ph;
                r_tot      <= n_tot;
                // write-back this edge lands after the read: take it from the bypass
                r_fwd_hit  <= b_wr_en && (r_b_addr == rd_addr);
                r_b_valid  <= 1'b1;
            end else if (b_adv) begin
                r_b_valid  <= 1'b0;
            end
            if (b_adv) begin
                r_c_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_close <= close;
            r_b_read  <= (i_in.cmd == grlh_pkg::CMD_READ_BIN) && idx_in_range;
            r_b_addr  <= rd_addr;
            r_b_tot   <= n_tot;
        end
        if (b_adv) begin
            r_c_bin <= r_b_read ? OW'(b_data) : '0;
            r_c_tot <= r_b_tot;
        end
    end

    assign o_out.valid           = r_c_valid;
    assign o_out.bin_count       = r_c_bin;
    assign o_out.gap_runs        = OW'(r_c_tot.runs);
    assign o_out.frameshift_runs = OW'(r_c_tot.frame);
    assign o_out.phase_zero_runs = OW'(r_c_tot.ph0);
    assign o_out.phase_one_runs  = OW'(r_c_tot.ph1);
    assign o_out.phase_two_runs  = OW'(r_c_tot.ph2);

    `GRLH_ASSERT_IMPL(a_no_item_in_clear, i_clk, i_rst_n, r_clr_active, !i_in.ready, "item taken during clear")
    `GRLH_ASSERT_IMPL(a_wb_not_in_clear, i_clk, i_rst_n, b_wr_en, !r_clr_active, "write-back during clear")
    `GRLH_ASSERT_IMPL(a_residue_idle, i_clk, i_rst_n, r_run_len == '0, r_run_res == 2'd0, "residue without open run")
    `GRLH_ASSERT_IMPL(a_frame_le_runs, i_clk, i_rst_n, r_tot.frame > r_tot.runs, 1'b0, "frameshift total above run total")
    `GRLH_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, accept, r_b_valid, "accepted item lost before RMW stage")

endmodule

`default_nettype wire

// ===== tb/tb_gap_run_length_histogram.sv =====
// Self-checking testbench for gap_run_length_histogram: directed and random command items,
// in-bench prediction of histogram and run totals, random idle on both channels.
// Depends on grlh_pkg, grlh_ifs and the block's RTL.
`default_nettype none

module tb_gap_run_length_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH  = 4096;
    localparam int HIST_LAST   = HIST_DEPTH - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_MAX    = 6;
    localparam int DRAIN_WAIT  = 4;

    // cmd 3 is not defined by the package; the block treats it like a totals read
    localparam logic [grlh_pkg::CMD_WIDTH-1:0]    CMD_UNUSED = 2'd3;
    localparam logic [grlh_pkg::SYMBOL_WIDTH-1:0] CHAR_A     = 8'h41;

    typedef struct packed {
        logic [grlh_pkg::CMD_WIDTH-1:0]    cmd;
        logic [grlh_pkg::SYMBOL_WIDTH-1:0] symbol;
        logic                              eos;
        logic [grlh_pkg::INDEX_WIDTH-1:0]  bin_index;
        logic [3:0]                        idle;
    } t_cmd_item;

    typedef struct packed {
        logic [grlh_pkg::OUT_WIDTH-1:0] bin_count;
        logic [grlh_pkg::OUT_WIDTH-1:0] gap_runs;
        logic [grlh_pkg::OUT_WIDTH-1:0] frameshift_runs;
        logic [grlh_pkg::OUT_WIDTH-1:0] phase_zero_runs;
        logic [grlh_pkg::OUT_WIDTH-1:0] phase_one_runs;
        logic [grlh_pkg::OUT_WIDTH-1:0] phase_two_runs;
    } t_tally;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [grlh_pkg::SYMBOL_WIDTH-1:0] cfg_wr_data;

    grlh_in_if  in_ch ();
    grlh_out_if out_ch ();

    gap_run_length_histogram i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // Predicted block state
    logic [grlh_pkg::OUT_WIDTH-1:0]    hist_bins [0:HIST_DEPTH-1];
    logic [grlh_pkg::INDEX_WIDTH-1:0]  open_len;
    logic [1:0]                        open_resid;
    logic [1:0]                        open_phase;
    logic [1:0]                        col_phase;
    logic [grlh_pkg::OUT_WIDTH-1:0]    run_count;
    logic [grlh_pkg::OUT_WIDTH-1:0]    frameshift_count;
    logic [grlh_pkg::OUT_WIDTH-1:0]    phase_count [0:2];
    logic [grlh_pkg::SYMBOL_WIDTH-1:0] gap_code;

    t_cmd_item cmd_q [$];
    t_tally    tally_q [$];

    t_cmd_item   cur_item;
    bit          drv_busy;
    int          drv_wait;
    int          stall_left;
    bit          out_quiet;
    int          errors;
    int unsigned cycle_count;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [grlh_pkg::OUT_WIDTH-1:0] sat_inc(
        logic [grlh_pkg::OUT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void close_run();
        logic [grlh_pkg::INDEX_WIDTH-1:0] bin;
        if (open_len == 0) return;
        bin = open_len;
        hist_bins[bin] = sat_inc(hist_bins[bin]);
        run_count = sat_inc(run_count);
        if (open_resid != 0) frameshift_count = sat_inc(frameshift_count);
        phase_count[open_phase] = sat_inc(phase_count[open_phase]);
        open_len = '0;
        open_resid = '0;
    endfunction

    function automatic t_tally apply_command(t_cmd_item it);
        t_tally r;
        r.bin_count = '0;
        if (it.cmd == grlh_pkg::CMD_PUSH) begin
            if (it.symbol == gap_code) begin
                if (open_len == 0) begin
                    open_phase = col_phase;
                    open_resid = '0;
                end
                if (open_len < HIST_LAST) open_len = open_len + 1'b1;
                open_resid = (open_resid == 2'd2) ? 2'd0 : open_resid + 1'b1;
                if (it.eos) close_run();
            end else begin
                close_run();
            end
            col_phase = (it.eos || col_phase == 2'd2) ? 2'd0 : col_phase + 1'b1;
        end else if (it.cmd == grlh_pkg::CMD_READ_BIN) begin
            r.bin_count = hist_bins[it.bin_index];
        end
        r.gap_runs        = run_count;
        r.frameshift_runs = frameshift_count;
        r.phase_zero_runs = phase_count[0];
        r.phase_one_runs  = phase_count[1];
        r.phase_two_runs  = phase_count[2];
        return r;
    endfunction

    // Driver: one item from cmd_q at a time, after its idle gap
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            drv_busy = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                tally_q.push_back(apply_command(cur_item));
                drv_busy = 1'b0;
            end
            if (!drv_busy && cmd_q.size() != 0) begin
                cur_item = cmd_q.pop_front();
                drv_wait = cur_item.idle;
                drv_busy = 1'b1;
            end
            if (drv_busy && drv_wait == 0) begin
                in_ch.valid           <= 1'b1;
                in_ch.cmd             <= cur_item.cmd;
                in_ch.symbol          <= cur_item.symbol;
                in_ch.end_of_sequence <= cur_item.eos;
                in_ch.bin_index       <= cur_item.bin_index;
            end else begin
                in_ch.valid <= 1'b0;
                if (drv_busy) drv_wait--;
            end
        end
    end

    task automatic check_field(string name, logic [grlh_pkg::OUT_WIDTH-1:0] want,
                               logic [grlh_pkg::OUT_WIDTH-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: compares each result item with the oldest prediction, stalls at random
    always @(posedge clk) begin
        t_tally want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (tally_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual gap_runs %0d",
                             $time, out_ch.gap_runs);
                end else begin
                    want = tally_q.pop_front();
                    check_field("bin_count", want.bin_count, out_ch.bin_count);
                    check_field("gap_runs", want.gap_runs, out_ch.gap_runs);
                    check_field("frameshift_runs", want.frameshift_runs,
                                out_ch.frameshift_runs);
                    check_field("phase_zero_runs", want.phase_zero_runs,
                                out_ch.phase_zero_runs);
                    check_field("phase_one_runs", want.phase_one_runs, out_ch.phase_one_runs);
                    check_field("phase_two_runs", want.phase_two_runs, out_ch.phase_two_runs);
                end
                if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
                stall_left = out_quiet ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_cmd(logic [grlh_pkg::CMD_WIDTH-1:0] cmd,
                            logic [grlh_pkg::SYMBOL_WIDTH-1:0] sym,
                            logic eos, logic [grlh_pkg::INDEX_WIDTH-1:0] idx, bit quiet);
        t_cmd_item it;
        it.cmd       = cmd;
        it.symbol    = sym;
        it.eos       = eos;
        it.bin_index = idx;
        it.idle      = quiet ? 4'd0 : 4'($urandom_range(0, IDLE_MAX));
        cmd_q.push_back(it);
    endtask

    function automatic logic [grlh_pkg::SYMBOL_WIDTH-1:0] non_gap_symbol();
        logic [grlh_pkg::SYMBOL_WIDTH-1:0] s;
        do s = grlh_pkg::SYMBOL_WIDTH'($urandom); while (s == gap_code);
        return s;
    endfunction

    function automatic logic [grlh_pkg::INDEX_WIDTH-1:0] pick_bin();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return grlh_pkg::INDEX_WIDTH'($urandom_range(0, 12));
        if (sel < 7) return grlh_pkg::INDEX_WIDTH'(HIST_LAST);
        return grlh_pkg::INDEX_WIDTH'($urandom);
    endfunction

    // Mostly well-formed sequences with gap runs; reads interleaved; some noise
    task automatic queue_random(int n);
        int made;
        int kind;
        int seq_len;
        int k;
        bit in_gap;
        bit quiet;
        logic [grlh_pkg::SYMBOL_WIDTH-1:0] s;
        made = 0;
        quiet = 1'b0;
        while (made < n) begin
            if ($urandom_range(0, 29) == 0) quiet = !quiet;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                seq_len = $urandom_range(1, 24);
                in_gap = $urandom_range(0, 1);
                for (k = 0; k < seq_len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_cmd(grlh_pkg::CMD_READ_BIN, grlh_pkg::SYMBOL_WIDTH'($urandom),
                                 1'($urandom), pick_bin(), quiet);
                        made++;
                    end
                    // sticky choice makes runs of varied length
                    if ($urandom_range(0, 2) == 0) in_gap = !in_gap;
                    s = in_gap ? gap_code : non_gap_symbol();
                    push_cmd(grlh_pkg::CMD_PUSH, s, k == seq_len - 1,
                             grlh_pkg::INDEX_WIDTH'($urandom), quiet);
                    made++;
                end
            end else if (kind < 82) begin
                push_cmd(grlh_pkg::CMD_READ_BIN, grlh_pkg::SYMBOL_WIDTH'($urandom),
                         1'($urandom), pick_bin(), quiet);
                made++;
            end else if (kind < 90) begin
                push_cmd(grlh_pkg::CMD_READ_TOTALS, grlh_pkg::SYMBOL_WIDTH'($urandom),
                         1'($urandom), grlh_pkg::INDEX_WIDTH'($urandom), quiet);
                made++;
            end else if (kind < 93) begin
                push_cmd(CMD_UNUSED, grlh_pkg::SYMBOL_WIDTH'($urandom), 1'($urandom),
                         grlh_pkg::INDEX_WIDTH'($urandom), quiet);
                made++;
            end else begin
                s = ($urandom_range(0, 2) == 0) ? gap_code : grlh_pkg::SYMBOL_WIDTH'($urandom);
                push_cmd(grlh_pkg::CMD_PUSH, s, 1'($urandom),
                         grlh_pkg::INDEX_WIDTH'($urandom), quiet);
                made++;
            end
        end
    endtask

    // Sender holds off until every predicted result has come back
    task automatic wait_drained();
        while (cmd_q.size() != 0 || drv_busy || tally_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_gap(logic [grlh_pkg::SYMBOL_WIDTH-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        gap_code = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int i;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        in_ch.valid           = 1'b0;
        in_ch.cmd             = grlh_pkg::CMD_PUSH;
        in_ch.symbol          = '0;
        in_ch.end_of_sequence = 1'b0;
        in_ch.bin_index       = '0;
        out_ch.ready          = 1'b0;
        errors                = 0;
        cycle_count           = 0;
        out_quiet             = 1'b0;
        drv_busy              = 1'b0;
        drv_wait              = 0;
        stall_left            = 0;
        for (i = 0; i < HIST_DEPTH; i++) hist_bins[i] = '0;
        open_len         = '0;
        open_resid       = '0;
        open_phase       = '0;
        col_phase        = '0;
        run_count        = '0;
        frameshift_count = '0;
        for (i = 0; i < 3; i++) phase_count[i] = '0;
        gap_code = grlh_pkg::GAP_SYMBOL_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_gap(grlh_pkg::GAP_SYMBOL_RESET);

        // Directed: empty reads, unused command, runs at each phase, eos closes
        push_cmd(grlh_pkg::CMD_READ_TOTALS, 8'h00, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_READ_BIN, 8'hFF, 1'b1, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_READ_BIN, 8'h00, 1'b0,
                 grlh_pkg::INDEX_WIDTH'(HIST_LAST), 1'b0);
        push_cmd(CMD_UNUSED, 8'hFF, 1'b1, 12'hFFF, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'hFFF, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, CHAR_A, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, CHAR_A, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b1, 12'd0, 1'b0);  // gap at eos joins the run
        push_cmd(grlh_pkg::CMD_PUSH, 8'h00, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, 8'hFF, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, CHAR_A, 1'b1, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b1, 12'd0, 1'b0);  // one-symbol sequence
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b1, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, 8'h00, 1'b1, 12'd0, 1'b0);
        push_cmd(grlh_pkg::CMD_READ_BIN, 8'h00, 1'b0, 12'd1, 1'b0);
        push_cmd(grlh_pkg::CMD_READ_BIN, 8'h00, 1'b0, 12'd2, 1'b0);
        push_cmd(grlh_pkg::CMD_READ_BIN, 8'h00, 1'b0, 12'd3, 1'b0);
        push_cmd(grlh_pkg::CMD_READ_TOTALS, 8'hFF, 1'b1, 12'hFFF, 1'b0);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);  // left open across the write
        wait_drained();

        write_gap(8'h00);
        queue_random(300);
        wait_drained();

        write_gap(8'hFF);
        queue_random(300);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        wait_drained();

        write_gap(grlh_pkg::SYMBOL_WIDTH'($urandom));
        queue_random(250);
        push_cmd(grlh_pkg::CMD_PUSH, gap_code, 1'b0, 12'd0, 1'b0);
        wait_drained();

        // Back to the default gap symbol; last bin and totals before more traffic
        write_gap(grlh_pkg::GAP_SYMBOL_RESET);
        push_cmd(grlh_pkg::CMD_READ_BIN, 8'h00, 1'b0,
                 grlh_pkg::INDEX_WIDTH'(HIST_LAST), 1'b0);
        push_cmd(grlh_pkg::CMD_READ_TOTALS, 8'h00, 1'b0, 12'd0, 1'b0);
        queue_random(400);
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== gap_run_length_histogram.f =====
+incdir+hw/rtl
hw/rtl/grlh_pkg.sv
hw/rtl/grlh_ifs.sv
hw/rtl/gap_run_length_histogram.sv
tb/tb_gap_run_length_histogram.sv
